// ----- rtl/core/psm_pkg.sv -----
package psm_pkg;

  // width of one pass of the shared multiplier
  localparam int unsigned MUL_W = 32;

  // widest data word the multiply-accumulate unit handles
  localparam int unsigned WORD_W = 64;

  // request from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic start;  // begin one wrapped product
    logic clear;  // zero the accumulator before adding the product
  } mac_req_t;

endpackage

// ----- rtl/core/psm_mac.sv -----
module psm_mac
  import psm_pkg::*;
#(
  parameter int unsigned DATA_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mac_req_t             req_i,
  input  logic [DATA_BITS-1:0] op_a_i,
  input  logic [DATA_BITS-1:0] op_b_i,
  output logic                 done_o,
  output logic [DATA_BITS-1:0] acc_o
);

  logic                 busy_q, busy_d;
  logic [1:0]           phase_q, phase_d;
  logic                 done_q, done_d;
  logic [DATA_BITS-1:0] acc_q, acc_d;
  logic [WORD_W-1:0]    prod_q, prod_d;

  logic [WORD_W-1:0]    a_wide, b_wide;
  logic [MUL_W-1:0]     mul_x, mul_y;
  logic [WORD_W-1:0]    addend, sum_wide;

  assign a_wide = WORD_W'(op_a_i);
  assign b_wide = WORD_W'(op_b_i);

  // low x low, then the two cross terms; high x high falls off the top
  always_comb begin
    case (phase_q)
      2'd1: begin
        mul_x = a_wide[WORD_W-1:MUL_W];
        mul_y = b_wide[MUL_W-1:0];
      end
      2'd2: begin
        mul_x = a_wide[MUL_W-1:0];
        mul_y = b_wide[WORD_W-1:MUL_W];
      end
      default: begin
        mul_x = a_wide[MUL_W-1:0];
        mul_y = b_wide[MUL_W-1:0];
      end
    endcase
  end

  assign prod_d   = WORD_W'(mul_x) * WORD_W'(mul_y);
  assign addend   = (phase_q == 2'd1) ? prod_q
                                      : {prod_q[MUL_W-1:0], {MUL_W{1'b0}}};
  assign sum_wide = WORD_W'(acc_q) + addend;

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    done_d  = 1'b0;
    acc_d   = acc_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      phase_d = 2'd0;
      if (req_i.clear) begin
        acc_d = '0;
      end
    end else if (busy_q) begin
      phase_d = phase_q + 2'd1;
      if (phase_q != 2'd0) begin
        acc_d = sum_wide[DATA_BITS-1:0];
      end
      if (phase_q == 2'd3) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 2'd0;
      done_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

// ----- rtl/core/power_sum_by_matrix_power_core.sv -----
// Returns s(n) = a^n + b^n from p = a+b (sum_ab), q = a*b (product_ab) and
// n (exponent), wrapped to DATA_BITS-bit two's complement and sign-extended
// to 64 bits; n = 0 gives 2 and n = 1 gives p. The matrix [[p,-q],[1,0]] is
// raised to n-1 by square-and-multiply over the low EXP_BITS exponent bits,
// and the result is p*R00 + 2*R01. Every product goes through one shared
// 32x32 multiplier in three passes (the high-by-high term falls off the
// top), and one 2x2 matrix product is eight wrapped products plus a decision
// and a commit step. After the input transfer an item takes one matrix
// product per set bit of n-1 plus one per bit position below its top bit,
// then the final combine and the output handoff; n = 0 goes straight to
// the output handoff. One item is worked at a time; in_ready_o is high only
// while the sequencer is idle, but a finished result held in the output
// register does not block the next transfer in.
module power_sum_by_matrix_power_core
  import psm_pkg::*;
#(
  parameter int unsigned DATA_BITS = 64,
  parameter int unsigned EXP_BITS  = 63
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] sum_ab_i,
  input  logic signed [31:0] product_ab_i,
  input  logic [62:0]        exponent_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] power_sum_o
);

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,  // waiting for an input transfer
    ST_LOOP   = 6'b000010,  // pick the next matrix operation
    ST_ISSUE  = 6'b000100,  // launch one product on the shared unit
    ST_WAIT   = 6'b001000,  // wait for the product to land
    ST_COMMIT = 6'b010000,  // copy the scratch matrix to its destination
    ST_OUT    = 6'b100000   // hand the result to the output register
  } state_e;

  // which operation the product index walks through
  typedef enum logic [2:0] {
    MODE_MULA  = 3'b001,  // acc = acc * base
    MODE_SQR   = 3'b010,  // base = base * base
    MODE_FINAL = 3'b100   // res = p*acc00 + 2*acc01
  } mode_e;

  localparam logic [DATA_BITS-1:0] ONE = DATA_BITS'(1);
  localparam logic [DATA_BITS-1:0] TWO = DATA_BITS'(2);

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;

  // product index: bit 2 is the row, bit 1 the column, bit 0 the inner term
  logic [2:0]          idx_q, idx_d;
  logic [EXP_BITS-1:0] k_q, k_d;

  logic                out_valid_q, out_valid_d;
  logic [DATA_BITS-1:0] out_data_q;

  // payload: p, the accumulated power, the squared base, scratch, result
  logic [DATA_BITS-1:0] p_q, p_d;
  logic [DATA_BITS-1:0] a00_q, a01_q, a10_q, a11_q;
  logic [DATA_BITS-1:0] a00_d, a01_d, a10_d, a11_d;
  logic [DATA_BITS-1:0] b00_q, b01_q, b10_q, b11_q;
  logic [DATA_BITS-1:0] b00_d, b01_d, b10_d, b11_d;
  logic [DATA_BITS-1:0] t00_q, t01_q, t10_q, t11_q;
  logic [DATA_BITS-1:0] t00_d, t01_d, t10_d, t11_d;
  logic [DATA_BITS-1:0] res_q, res_d;

  logic                 in_xfer;
  logic [EXP_BITS-1:0]  n_low;

  mac_req_t             mac_req;
  logic [DATA_BITS-1:0] op_a, op_b;
  logic                 mac_done;
  logic [DATA_BITS-1:0] mac_acc;

  // left operand row, right operand column
  logic [DATA_BITS-1:0] x_r0, x_r1, y_c0, y_c1;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign n_low      = exponent_i[EXP_BITS-1:0];

  // operand selection for the shared unit
  always_comb begin
    // row idx[2] of the left matrix
    if (mode_q == MODE_SQR) begin
      x_r0 = idx_q[2] ? b10_q : b00_q;
      x_r1 = idx_q[2] ? b11_q : b01_q;
    end else begin
      x_r0 = idx_q[2] ? a10_q : a00_q;
      x_r1 = idx_q[2] ? a11_q : a01_q;
    end
    // column idx[1] of the base
    y_c0 = idx_q[1] ? b01_q : b00_q;
    y_c1 = idx_q[1] ? b11_q : b10_q;

    if (mode_q == MODE_FINAL) begin
      op_a = idx_q[0] ? TWO : p_q;
      op_b = idx_q[0] ? a01_q : a00_q;
    end else begin
      op_a = idx_q[0] ? x_r1 : x_r0;
      op_b = idx_q[0] ? y_c1 : y_c0;
    end
  end

  // each product starts a fresh sum on its first inner term
  assign mac_req.start = (state_q == ST_ISSUE);
  assign mac_req.clear = !idx_q[0];

  psm_mac #(
    .DATA_BITS (DATA_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    idx_d       = idx_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    p_d   = p_q;
    res_d = res_q;
    a00_d = a00_q; a01_d = a01_q; a10_d = a10_q; a11_d = a11_q;
    b00_d = b00_q; b01_d = b01_q; b10_d = b10_q; b11_d = b11_q;
    t00_d = t00_q; t01_d = t01_q; t10_d = t10_q; t11_d = t11_q;

    // output register drains independently of the sequencer
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          p_d   = DATA_BITS'(sum_ab_i);
          a00_d = ONE;
          a01_d = '0;
          a10_d = '0;
          a11_d = ONE;
          b00_d = DATA_BITS'(sum_ab_i);
          b01_d = DATA_BITS'(0) - DATA_BITS'(product_ab_i);
          b10_d = ONE;
          b11_d = '0;
          k_d   = n_low - EXP_BITS'(1);
          if (n_low == '0) begin
            // zero exponent: a^0 + b^0
            res_d   = TWO;
            state_d = ST_OUT;
          end else begin
            state_d = ST_LOOP;
          end
        end
      end

      ST_LOOP: begin
        idx_d   = 3'd0;
        state_d = ST_ISSUE;
        if (k_q == '0) begin
          mode_d = MODE_FINAL;
        end else if (k_q[0]) begin
          mode_d = MODE_MULA;
        end else begin
          // even and nonzero, so the square is still needed
          mode_d = MODE_SQR;
        end
      end

      ST_ISSUE: begin
        state_d = ST_WAIT;
      end

      ST_WAIT: begin
        if (mac_done) begin
          if (mode_q == MODE_FINAL) begin
            if (idx_q[0]) begin
              res_d   = mac_acc;
              state_d = ST_OUT;
            end else begin
              idx_d   = 3'd1;
              state_d = ST_ISSUE;
            end
          end else begin
            if (idx_q[0]) begin
              case (idx_q[2:1])
                2'd0:    t00_d = mac_acc;
                2'd1:    t01_d = mac_acc;
                2'd2:    t10_d = mac_acc;
                default: t11_d = mac_acc;
              endcase
            end
            if (idx_q == 3'd7) begin
              state_d = ST_COMMIT;
            end else begin
              idx_d   = idx_q + 3'd1;
              state_d = ST_ISSUE;
            end
          end
        end
      end

      ST_COMMIT: begin
        if (mode_q == MODE_MULA) begin
          a00_d = t00_q; a01_d = t01_q; a10_d = t10_q; a11_d = t11_q;
          k_d   = k_q & ~EXP_BITS'(1);
        end else begin
          b00_d = t00_q; b01_d = t01_q; b10_d = t10_q; b11_d = t11_q;
          k_d   = k_q >> 1;
        end
        state_d = ST_LOOP;
      end

      ST_OUT: begin
        // wait until the output register is free or being emptied
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_FINAL;
      idx_q       <= 3'd0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      idx_q       <= idx_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= p_d;
    res_q <= res_d;
    a00_q <= a00_d; a01_q <= a01_d; a10_q <= a10_d; a11_q <= a11_d;
    b00_q <= b00_d; b01_q <= b01_d; b10_q <= b10_d; b11_q <= b11_d;
    t00_q <= t00_d; t01_q <= t01_d; t10_q <= t10_d; t11_q <= t11_d;
    if (state_q == ST_OUT && (!out_valid_q || out_ready_i)) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign power_sum_o = WORD_W'($signed(out_data_q));

endmodule

// ----- sim/tb_power_sum_by_matrix_power_core.sv -----
`timescale 1ns / 100ps

module tb_power_sum_by_matrix_power_core;

  // clock period in ns, reset length in cycles
  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RESET_CYCLES = 10;
  // covers ~600 items of the worst size with heavy receiver stall, taken
  // several times over
  localparam int unsigned CYCLE_LIMIT  = 16_000_000;
  // quiet cycles after the last result to catch stray outputs
  localparam int unsigned TAIL_CYCLES  = 64;
  // random items per pacing phase (four phases)
  localparam int unsigned PHASE_ITEMS  = 140;

  // one input transfer: p, q and n
  typedef struct packed {
    logic signed [31:0] sum_ab;
    logic signed [31:0] product_ab;
    logic [62:0]        exponent;
  } root_term_t;

  // one outstanding result with the inputs that caused it
  typedef struct packed {
    root_term_t  term;
    logic [63:0] sum;
  } expected_sum_t;

  // 2x2 matrix in wrapping 64-bit arithmetic
  typedef struct packed {
    logic [63:0] m00;
    logic [63:0] m01;
    logic [63:0] m10;
    logic [63:0] m11;
  } sq_mat_t;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] sum_ab_i     = '0;
  logic signed [31:0] product_ab_i = '0;
  logic [62:0]        exponent_i   = '0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic signed [63:0] power_sum_o;

  // items waiting to be driven, and results waiting to come back
  root_term_t    pending_terms[$];
  expected_sum_t expected_sums[$];

  // pacing: percent of cycles the sender idles / the receiver stalls
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  int unsigned cycle_cnt    = 0;
  int unsigned err_cnt      = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt  = 0;
  int unsigned wide_exp_cnt = 0;

  power_sum_by_matrix_power_core #(
    .DATA_BITS(64),
    .EXP_BITS (63)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sum_ab_i    (sum_ab_i),
    .product_ab_i(product_ab_i),
    .exponent_i  (exponent_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .power_sum_o (power_sum_o)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------

  // plain 2x2 product, every entry wrapped to 64 bits
  function automatic sq_mat_t mat_product(sq_mat_t a, sq_mat_t b);
    sq_mat_t r;
    r.m00 = a.m00 * b.m00 + a.m01 * b.m10;
    r.m01 = a.m00 * b.m01 + a.m01 * b.m11;
    r.m10 = a.m10 * b.m00 + a.m11 * b.m10;
    r.m11 = a.m10 * b.m01 + a.m11 * b.m11;
    return r;
  endfunction

  // a^n + b^n from p = a+b and q = ab: raise [[p,-q],[1,0]] to n-1 by
  // square-and-multiply from the low exponent bit up, then p*R00 + 2*R01
  function automatic logic [63:0] root_power_sum(logic signed [31:0] p_in,
                                                 logic signed [31:0] q_in,
                                                 logic [62:0] n);
    logic [63:0] p;
    logic [63:0] q;
    logic [62:0] k;
    sq_mat_t     base;
    sq_mat_t     acc;
    p = {{32{p_in[31]}}, p_in};
    q = {{32{q_in[31]}}, q_in};
    // zero exponent: both roots to the zeroth power
    if (n == '0) return 64'd2;
    k    = n - 63'd1;
    base = '{m00: p, m01: 64'd0 - q, m10: 64'd1, m11: 64'd0};
    // unit exponent leaves the identity here, so the result is p
    acc  = '{m00: 64'd1, m01: 64'd0, m10: 64'd0, m11: 64'd1};
    while (k != '0) begin
      if (k[0]) acc = mat_product(acc, base);
      base = mat_product(base, base);
      k    = k >> 1;
    end
    return p * acc.m00 + 64'd2 * acc.m01;
  endfunction

  // ---------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------

  task automatic add_term(logic signed [31:0] p, logic signed [31:0] q, logic [62:0] n);
    root_term_t t;
    t.sum_ab     = p;
    t.product_ab = q;
    t.exponent   = n;
    pending_terms.push_back(t);
  endtask

  // root sum / product: small values keep results exact, extremes and full
  // random words exercise wrapping and every bit
  function automatic logic signed [31:0] pick_operand();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 40) return $signed($urandom_range(16)) - 32'sd8;
    if (sel < 50) begin
      case ($urandom_range(3))
        0:       return 32'sh8000_0000;
        1:       return 32'sh7fff_ffff;
        2:       return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $signed($urandom);
  endfunction

  // exponent cost grows with its bit length, so most are short and only a
  // few reach the full 63 bits
  function automatic root_term_t random_term();
    root_term_t  t;
    int unsigned sel;
    logic [63:0] wide;
    t.sum_ab     = pick_operand();
    t.product_ab = pick_operand();
    sel = $urandom_range(99);
    wide = {$urandom, $urandom};
    if (sel < 8)       t.exponent = wide[62:0];
    else if (sel < 30) t.exponent = 63'($urandom_range(65535));
    else if (sel < 42) t.exponent = 63'($urandom_range(3));
    else               t.exponent = 63'($urandom_range(63));
    return t;
  endfunction

  // idle until every queued item went in and every result came back;
  // sampled on the falling edge so the clocked blocks have settled
  task automatic wait_drained();
    while (pending_terms.size() != 0 || in_valid_i || expected_sums.size() != 0)
      @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // driver: feeds pending_terms into the input channel
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : drive_terms
    root_term_t    nxt;
    expected_sum_t want;
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      sum_ab_i     <= '0;
      product_ab_i <= '0;
      exponent_i   <= '0;
    end else begin
      // transfer on this edge: predict from the payload being taken
      if (in_valid_i && in_ready_o) begin
        want.term.sum_ab     = sum_ab_i;
        want.term.product_ab = product_ab_i;
        want.term.exponent   = exponent_i;
        want.sum = root_power_sum(sum_ab_i, product_ab_i, exponent_i);
        expected_sums.push_back(want);
        accepted_cnt++;
        if (exponent_i[62:32] != '0) wide_exp_cnt++;
      end
      // valid may only change once nothing is held or the held item moved
      if (!in_valid_i || in_ready_o) begin
        if (pending_terms.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_terms.pop_front();
          in_valid_i   <= 1'b1;
          sum_ab_i     <= nxt.sum_ab;
          product_ab_i <= nxt.product_ab;
          exponent_i   <= nxt.exponent;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // monitor: checks each result transfer against the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : check_sums
    expected_sum_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        checked_cnt++;
        if (expected_sums.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result power_sum=%0d, nothing outstanding",
                   $time, power_sum_o);
        end else begin
          want = expected_sums.pop_front();
          if (power_sum_o !== want.sum) begin
            err_cnt++;
            $display("%0t: power_sum mismatch p=%0d q=%0d n=%0d expected=%0d actual=%0d",
                     $time, want.term.sum_ab, want.term.product_ab,
                     want.term.exponent, $signed(want.sum), power_sum_o);
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------
  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin : watchdog
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------
  // sequence: reset, directed items, then four paced random phases
  // ---------------------------------------------------------------------
  initial begin : run_sequence
    int unsigned phase;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part, no idling
    // zero exponent, with extreme roots
    add_term(32'sh7fff_ffff, 32'sh8000_0000, 63'd0);
    add_term(32'sh8000_0000, 32'sh7fff_ffff, 63'd0);
    // unit exponent returns p as is
    add_term(32'sh8000_0000, 32'sd5, 63'd1);
    add_term(32'sh7fff_ffff, -32'sd1, 63'd1);
    // n = 2 and 3: p^2 - 2q and p^3 - 3pq
    add_term(32'sd7, 32'sd3, 63'd2);
    add_term(-32'sd4, 32'sd9, 63'd3);
    // a = b = 1 gives 2 for every n, up to the widest exponent
    add_term(32'sd2, 32'sd1, 63'h7fff_ffff_ffff_ffff);
    // all-zero roots: only n = 0 is nonzero
    add_term(32'sd0, 32'sd0, 63'h4000_0000_0000_0000);
    add_term(32'sd0, 32'sd0, 63'd64);
    // Lucas numbers, still exact at n = 90
    add_term(32'sd1, -32'sd1, 63'd90);
    // roots 1 and 2: 1 + 2^62 exact, then 1 + 2^63 wraps negative
    add_term(32'sd3, 32'sd2, 63'd62);
    add_term(32'sd3, 32'sd2, 63'd63);
    // heavy overflow in every product
    add_term(32'sh7fff_ffff, 32'sh8000_0000, 63'd5);
    add_term(32'sh8000_0000, 32'sh7fff_ffff, 63'h7fff_ffff_ffff_ffff);
    add_term(-32'sd1, -32'sd1, 63'h5555_5555_5555_5555);
    // an all-ones word, and the top exponent bit together with bit 0
    add_term(-32'sd1, 32'sh8000_0000, 63'h2aaa_aaaa_aaaa_aaaa);
    add_term(32'sd5, -32'sd7, 63'h4000_0000_0000_0001);
    wait_drained();

    // random part: no idling, sender idle, receiver stall, both lightly
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      repeat (PHASE_ITEMS) pending_terms.push_back(random_term());
      wait_drained();
    end

    // let any stray result show up before closing
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d power-sum transfers in, %0d results checked, %0d errors",
             accepted_cnt, checked_cnt, err_cnt);
    $display("%0d items had exponents above 32 bits; pacing ran free, sender-idle, %s",
             wide_exp_cnt, "receiver-stall and mixed");
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/psm_pkg.sv
rtl/core/psm_mac.sv
rtl/core/power_sum_by_matrix_power_core.sv
sim/tb_power_sum_by_matrix_power_core.sv
